// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LAP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LAP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lap_pkg.sv -----
// Types and constants for the listen address parser.
`timescale 1ns / 1ps

package lap_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned PortW    = 16;
  localparam int unsigned NumW     = 17;   // port value, saturates at 65536
  localparam int unsigned FieldW   = 10;   // one address field, up to 999
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;

  localparam logic [NumW-1:0]  NumSat       = 17'd65536;
  localparam logic [NumW-1:0]  PortMax      = 17'd65535;
  localparam logic [FieldW-1:0] FieldMax    = 10'd255;
  localparam logic [PortW-1:0] DefaultPortRst = 16'd80;

  // Register index, taken from paddr above the byte offset.
  localparam logic CfgDefaultPort = 1'b0;

  localparam logic [ByteW-1:0] ChColon = 8'h3A;
  localparam logic [ByteW-1:0] ChDot   = 8'h2E;
  localparam logic [ByteW-1:0] ChPlus  = 8'h2B;
  localparam logic [ByteW-1:0] ChMinus = 8'h2D;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  typedef enum logic [2:0] {
    CL_COLON,
    CL_DOT,
    CL_DIGIT,
    CL_SPACE,
    CL_PLUS,
    CL_MINUS,
    CL_OTHER
  } char_class_e;

  typedef enum logic [1:0] {
    NP_SKIP,
    NP_DIGITS,
    NP_STOP
  } num_phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK,
    ST_MALFORMED,
    ST_PORT_RANGE,
    ST_BAD_ADDR
  } status_e;

  typedef struct packed {
    char_class_e       cls;
    logic [DigitW-1:0] digit;
    logic              last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

// ----- hw/rtl/lap_front.sv -----
// Front end: classifies each incoming character for the back end.
`timescale 1ns / 1ps

module lap_front (
  input  logic [lap_pkg::ByteW-1:0] text_byte_i,
  input  logic                      final_byte_i,
  output lap_pkg::item_t            item_o
);

  logic [lap_pkg::ByteW-1:0] rel;

  assign rel = text_byte_i - lap_pkg::ChZero;

  always_comb begin
    item_o.last  = final_byte_i;
    item_o.digit = rel[lap_pkg::DigitW-1:0];
    if (text_byte_i == lap_pkg::ChColon) begin
      item_o.cls = lap_pkg::CL_COLON;
    end else if (text_byte_i == lap_pkg::ChDot) begin
      item_o.cls = lap_pkg::CL_DOT;
    end else if (text_byte_i >= lap_pkg::ChZero && text_byte_i <= lap_pkg::ChNine) begin
      item_o.cls = lap_pkg::CL_DIGIT;
    end else if (text_byte_i == lap_pkg::ChSpace ||
                 (text_byte_i >= lap_pkg::ChTab && text_byte_i <= lap_pkg::ChCr)) begin
      item_o.cls = lap_pkg::CL_SPACE;
    end else if (text_byte_i == lap_pkg::ChPlus) begin
      item_o.cls = lap_pkg::CL_PLUS;
    end else if (text_byte_i == lap_pkg::ChMinus) begin
      item_o.cls = lap_pkg::CL_MINUS;
    end else begin
      item_o.cls = lap_pkg::CL_OTHER;
    end
  end

endmodule

// ----- hw/rtl/lap_queue.sv -----
// Short FIFO of classified characters between front and back end.
`timescale 1ns / 1ps

module lap_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lap_pkg::item_t       push_item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output lap_pkg::queue_head_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lap_pkg::item_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q + CntW'(do_push) - CntW'(do_pop);
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- hw/rtl/lap_back.sv -----
// Back end: parse state, verdict on the final character, result register.
`timescale 1ns / 1ps

module lap_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lap_pkg::queue_head_t       head_i,
  output logic                       pop_o,
  input  logic [lap_pkg::PortW-1:0]  default_port_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output lap_pkg::status_e           status_o,
  output logic [lap_pkg::AddrW-1:0]  address_o,
  output logic [lap_pkg::PortW-1:0]  port_number_o,
  output logic                       port_was_default_o
);

  // parse state
  logic [1:0]                  colon_cnt_q, colon_cnt_d;
  logic                        has_chars_q, has_chars_d;
  logic                        first_empty_q, first_empty_d;
  logic [2:0]                  dot_cnt_q, dot_cnt_d;
  logic [2:0]                  field_len_q, field_len_d;
  logic [lap_pkg::FieldW-1:0]  field_val_q, field_val_d;
  logic                        addr_bad_q, addr_bad_d;
  logic [lap_pkg::AddrW-1:0]   addr_acc_q, addr_acc_d;
  lap_pkg::num_phase_e         phase_q, phase_d;
  logic                        negative_q, negative_d;
  logic [lap_pkg::NumW-1:0]    num_val_q, num_val_d;

  // result register
  logic                        res_valid_q, res_valid_d;
  lap_pkg::status_e            status_q, status_d;
  logic [lap_pkg::AddrW-1:0]   address_q, address_d;
  logic [lap_pkg::PortW-1:0]   port_q, port_d;
  logic                        dflt_q, dflt_d;

  logic                        res_free;
  logic                        finish;

  assign res_free = !res_valid_q || res_ready_i;
  assign pop_o    = head_i.valid && (!head_i.item.last || res_free);
  assign finish   = pop_o && head_i.item.last;

  always_comb begin
    logic [13:0]              fmul;
    logic [20:0]              nmul;
    logic                     malformed;
    logic                     dotted_only;
    logic [lap_pkg::NumW-1:0] port_val;

    colon_cnt_d   = colon_cnt_q;
    has_chars_d   = has_chars_q;
    first_empty_d = first_empty_q;
    dot_cnt_d     = dot_cnt_q;
    field_len_d   = field_len_q;
    field_val_d   = field_val_q;
    addr_bad_d    = addr_bad_q;
    addr_acc_d    = addr_acc_q;
    phase_d       = phase_q;
    negative_d    = negative_q;
    num_val_d     = num_val_q;
    fmul = 14'(field_val_q) * 14'd10 + 14'(head_i.item.digit);
    nmul = 21'(num_val_q) * 21'd10 + 21'(head_i.item.digit);

    if (head_i.item.cls == lap_pkg::CL_COLON) begin
      if (colon_cnt_q == 2'd0) first_empty_d = !has_chars_q;
      if (colon_cnt_q != 2'd2) colon_cnt_d = colon_cnt_q + 2'd1;
      has_chars_d = 1'b0;
      phase_d     = lap_pkg::NP_SKIP;
      negative_d  = 1'b0;
      num_val_d   = '0;
    end else begin
      has_chars_d = 1'b1;
      // address field, first part only
      if (colon_cnt_q == 2'd0) begin
        case (head_i.item.cls)
          lap_pkg::CL_DIGIT: begin
            if (field_len_q >= 3'd3) begin
              field_len_d = 3'd4;
              addr_bad_d  = 1'b1;
            end else begin
              field_val_d = fmul[lap_pkg::FieldW-1:0];
              field_len_d = field_len_q + 3'd1;
            end
          end
          lap_pkg::CL_DOT: begin
            if (field_len_q == 3'd0 || field_len_q > 3'd3 ||
                field_val_q > lap_pkg::FieldMax || dot_cnt_q >= 3'd3) begin
              addr_bad_d = 1'b1;
            end
            addr_acc_d  = {addr_acc_q[23:0], field_val_q[7:0]};
            if (dot_cnt_q < 3'd4) dot_cnt_d = dot_cnt_q + 3'd1;
            field_len_d = '0;
            field_val_d = '0;
          end
          default: addr_bad_d = 1'b1;
        endcase
      end
      // atoi-style port reader
      if (phase_q == lap_pkg::NP_SKIP && head_i.item.cls == lap_pkg::CL_SPACE) begin
        phase_d = lap_pkg::NP_SKIP;
      end else if (phase_q == lap_pkg::NP_SKIP && head_i.item.cls == lap_pkg::CL_PLUS) begin
        phase_d = lap_pkg::NP_DIGITS;
      end else if (phase_q == lap_pkg::NP_SKIP && head_i.item.cls == lap_pkg::CL_MINUS) begin
        phase_d    = lap_pkg::NP_DIGITS;
        negative_d = 1'b1;
      end else if (phase_q != lap_pkg::NP_STOP && head_i.item.cls == lap_pkg::CL_DIGIT) begin
        phase_d   = lap_pkg::NP_DIGITS;
        num_val_d = (nmul > 21'(lap_pkg::NumSat)) ? lap_pkg::NumSat
                                                  : nmul[lap_pkg::NumW-1:0];
      end else begin
        phase_d = lap_pkg::NP_STOP;
      end
    end

    // verdict, on the updated state
    malformed   = (colon_cnt_d == 2'd2) ||
                  (colon_cnt_d == 2'd1 && (first_empty_d || !has_chars_d));
    dotted_only = (colon_cnt_d == 2'd0) && (dot_cnt_d != 3'd0);
    port_val    = dotted_only ? lap_pkg::NumW'(default_port_i)
                              : (negative_d ? '0 : num_val_d);
    address_d   = '0;
    port_d      = '0;
    dflt_d      = 1'b0;
    if (malformed) begin
      status_d = lap_pkg::ST_MALFORMED;
    end else if ((negative_d && !dotted_only) || port_val == '0 ||
                 port_val > lap_pkg::PortMax) begin
      status_d = lap_pkg::ST_PORT_RANGE;
    end else if (colon_cnt_d == 2'd0 && dot_cnt_d == 3'd0) begin
      status_d = lap_pkg::ST_OK;
      port_d   = port_val[lap_pkg::PortW-1:0];
    end else if (addr_bad_d || dot_cnt_d != 3'd3 || field_len_d == 3'd0 ||
                 field_len_d > 3'd3 || field_val_d > lap_pkg::FieldMax) begin
      status_d = lap_pkg::ST_BAD_ADDR;
    end else begin
      status_d  = lap_pkg::ST_OK;
      address_d = {addr_acc_d[23:0], field_val_d[7:0]};
      port_d    = port_val[lap_pkg::PortW-1:0];
      dflt_d    = dotted_only;
    end

    if (finish) begin
      colon_cnt_d   = '0;
      has_chars_d   = 1'b0;
      first_empty_d = 1'b0;
      dot_cnt_d     = '0;
      field_len_d   = '0;
      field_val_d   = '0;
      addr_bad_d    = 1'b0;
      addr_acc_d    = '0;
      phase_d       = lap_pkg::NP_SKIP;
      negative_d    = 1'b0;
      num_val_d     = '0;
    end

    res_valid_d = finish ? 1'b1 : (res_valid_q && !res_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colon_cnt_q   <= '0;
      has_chars_q   <= 1'b0;
      first_empty_q <= 1'b0;
      dot_cnt_q     <= '0;
      field_len_q   <= '0;
      field_val_q   <= '0;
      addr_bad_q    <= 1'b0;
      addr_acc_q    <= '0;
      phase_q       <= lap_pkg::NP_SKIP;
      negative_q    <= 1'b0;
      num_val_q     <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      if (pop_o) begin
        colon_cnt_q   <= colon_cnt_d;
        has_chars_q   <= has_chars_d;
        first_empty_q <= first_empty_d;
        dot_cnt_q     <= dot_cnt_d;
        field_len_q   <= field_len_d;
        field_val_q   <= field_val_d;
        addr_bad_q    <= addr_bad_d;
        addr_acc_q    <= addr_acc_d;
        phase_q       <= phase_d;
        negative_q    <= negative_d;
        num_val_q     <= num_val_d;
      end
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      status_q  <= status_d;
      address_q <= address_d;
      port_q    <= port_d;
      dflt_q    <= dflt_d;
    end
  end

  assign res_valid_o        = res_valid_q;
  assign status_o           = status_q;
  assign address_o          = address_q;
  assign port_number_o      = port_q;
  assign port_was_default_o = dflt_q;

endmodule

// ----- hw/rtl/listen_address_parser_core.sv -----
// Top level of the listen address parser: stream ports, config register.
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata[7:0] text_byte, tlast final_byte
//  m_axis    out  tvalid/tready           tdata status/address/port/default flag
//  apb       in   psel/penable, pready=1  reg 0 default_port at byte address 0
//
// Throughput is one character per cycle unless a final character waits on a pending
// result: otherwise the back end retires one queued transaction per clock, with one
// multiply-by-ten per accumulator in its path. m_axis_tvalid rises once the final
// character has passed through the queue and then loaded the result register.
// Reset clears all parse state and the queue, and sets default_port to 80.
// A waiting result holds back only a final character; s_axis stalls once the queue fills.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module listen_address_parser_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream; tdata: [7:0] text_byte
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lap_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tlast,
  // result stream; tdata: [1:0] status, [33:2] address, [49:34] port_number,
  // [50] port_was_default, [55:51] zero
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lap_pkg::OutDataW-1:0]  m_axis_tdata,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lap_pkg::PaddrW-1:0]    paddr,
  input  logic [lap_pkg::PdataW-1:0]    pwdata,
  output logic [lap_pkg::PdataW-1:0]    prdata,
  output logic                          pready
);

  logic [lap_pkg::PortW-1:0] default_port_q, default_port_d;
  logic                      cfg_hit;

  lap_pkg::item_t            front_item;
  lap_pkg::queue_head_t      head;
  logic                      queue_full;
  logic                      pop;

  lap_pkg::status_e          res_status;
  logic [lap_pkg::AddrW-1:0] res_address;
  logic [lap_pkg::PortW-1:0] res_port;
  logic                      res_dflt;

  // config register
  assign pready  = 1'b1;
  assign cfg_hit = psel && penable && pwrite && (paddr[2] == lap_pkg::CfgDefaultPort);
  assign default_port_d = cfg_hit ? pwdata[lap_pkg::PortW-1:0] : default_port_q;
  assign prdata  = (paddr[2] == lap_pkg::CfgDefaultPort)
                   ? lap_pkg::PdataW'(default_port_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_port_q <= lap_pkg::DefaultPortRst;
    end else begin
      default_port_q <= default_port_d;
    end
  end

  // front: classify, then queue
  lap_front u_front (
    .text_byte_i  (s_axis_tdata),
    .final_byte_i (s_axis_tlast),
    .item_o       (front_item)
  );

  assign s_axis_tready = !queue_full;

  lap_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_i       (pop),
    .head_o      (head)
  );

  // back: parse and emit
  lap_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (head),
    .pop_o              (pop),
    .default_port_i     (default_port_q),
    .res_valid_o        (m_axis_tvalid),
    .res_ready_i        (m_axis_tready),
    .status_o           (res_status),
    .address_o          (res_address),
    .port_number_o      (res_port),
    .port_was_default_o (res_dflt)
  );

  assign m_axis_tdata = {5'b0, res_dflt, res_port, res_address, res_status};

  // checks
  `LAP_ASSERT_IMP(a_fail_zero, m_axis_tvalid && res_status != lap_pkg::ST_OK, res_address == '0 && res_port == '0 && !res_dflt, "failed result carries data")
  `LAP_ASSERT_IMP(a_ok_port, m_axis_tvalid && res_status == lap_pkg::ST_OK, res_port != '0, "ok result with zero port")
  `LAP_ASSERT_IMP(a_pop_head, pop, head.valid, "pop from empty queue")
  `LAP_ASSERT_NXT(a_final_res, pop && head.item.last, m_axis_tvalid, "final character lost its result")

endmodule
